[hw/rtl/assert_macros.svh]
// assert_macros.svh: assertion helpers shared by the averager RTL.
// Each macro expects a clock named clk in scope; CHECK_RST also needs a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is high.
`define CHECK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that is also evaluated during reset.
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/nwsa_pkg.sv]
// nwsa_pkg: shared widths, constants and the sentence request type.
// Used by the front end, the request queue, the back end and the top level.
package nwsa_pkg;

  // Field accumulator width (hundredths, saturating at 99999)
  localparam int ACC_W = 17;
  // Result widths
  localparam int DIR_W = 17;
  localparam int SPD_W = 19;

  // Depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // One parsed sentence handed from front to back
  typedef struct packed {
    logic [ACC_W-1:0] dir_accum;
    logic [ACC_W-1:0] speed_accum;
  } sentence_t;

endpackage

[hw/rtl/nmea_wind_sentence_averager.sv]
// nmea_wind_sentence_averager: top level of the MWV wind sentence averager.
// Depends on nwsa_pkg, nwsa_front, nwsa_queue and nwsa_back.
//
// Usage:
//  - Input channel (in_valid/in_ready/rx_byte) takes one received character
//    per request, one per cycle while in_ready is high.
//  - A '$' after the first byte of a line closes the sentence; a sentence that
//    starts with "$IIMWV" yields one result request on the output channel
//    (out_valid/out_ready), all other sentences yield none.
//  - After the closing '$' is taken, the result passes through the request
//    queue, product stage, ring stage, reciprocal stage and output reg.
//  - The back end takes one sentence per cycle unless the output stalls.
//  - When the receiver stalls, the back end holds and sentences collect in a
//    4-entry queue; in_ready drops only while that queue is full.
//  - APB register 0 (byte address 0): speed_limit_milli, 19 bits, reset
//    100000; write only while the block is idle.
//  - Reset (synchronous, rst high) clears the line parser, both averaging
//    rings and the averages, and returns the limit to its reset value.
module nmea_wind_sentence_averager #(
  parameter int SAMPLE_COUNT = 5,
  parameter int LINE_LENGTH  = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // byte input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        rx_byte,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              rejected,
  output logic signed [nwsa_pkg::DIR_W-1:0] direction_centideg,
  output logic [nwsa_pkg::SPD_W-1:0]        speed_milli,
  output logic signed [nwsa_pkg::DIR_W-1:0] avg_direction_centideg,
  output logic [nwsa_pkg::SPD_W-1:0]        avg_speed_milli,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam logic REG_SPEED_LIMIT = 1'b0;
  localparam logic [nwsa_pkg::SPD_W-1:0] LIMIT_RESET = nwsa_pkg::SPD_W'(100000);

  logic                       in_fire;
  logic                       push;
  nwsa_pkg::sentence_t        push_data;
  logic                       q_valid;
  logic                       q_full;
  logic                       q_pop;
  nwsa_pkg::sentence_t        q_head;
  logic [nwsa_pkg::SPD_W-1:0] speed_limit_milli;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPEED_LIMIT) ?
                  32'(speed_limit_milli) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit_milli <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SPEED_LIMIT) begin
      speed_limit_milli <= pwdata[nwsa_pkg::SPD_W-1:0];
    end
  end

  nwsa_front #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .rx_byte  (rx_byte),
    .push     (push),
    .push_data(push_data)
  );

  nwsa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (q_pop),
    .valid    (q_valid),
    .full     (q_full),
    .head     (q_head)
  );

  nwsa_back #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_back (
    .clk                   (clk),
    .rst                   (rst),
    .q_valid               (q_valid),
    .q_data                (q_head),
    .q_pop                 (q_pop),
    .speed_limit_milli     (speed_limit_milli),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .rejected              (rejected),
    .direction_centideg    (direction_centideg),
    .speed_milli           (speed_milli),
    .avg_direction_centideg(avg_direction_centideg),
    .avg_speed_milli       (avg_speed_milli)
  );

endmodule

[hw/rtl/nwsa_front.sv]
// nwsa_front: byte-level sentence framing, header check and field parsing.
// Depends on nwsa_pkg; pushes one sentence_t per finished MWV sentence.
`include "assert_macros.svh"

module nwsa_front #(
  parameter int LINE_LENGTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic [7:0]          rx_byte,
  output logic                push,
  output nwsa_pkg::sentence_t push_data
);

  localparam int POS_W = $clog2(LINE_LENGTH);
  localparam logic [POS_W-1:0] POS_MAX      = POS_W'(LINE_LENGTH - 1);
  localparam logic [POS_W-1:0] HEADER_LEN   = POS_W'(6);
  localparam logic [POS_W-1:0] DIR_FIRST    = POS_W'(7);
  localparam logic [POS_W-1:0] DIR_LAST     = POS_W'(11);
  localparam logic [POS_W-1:0] SPD_FIRST    = POS_W'(15);
  localparam logic [POS_W-1:0] SPD_LAST     = POS_W'(19);

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_POINT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [20:0] SAT_VALUE  = 21'd99999;

  typedef struct packed {
    logic [1:0] frac;    // decimals taken
    logic       point;   // decimal point seen
    logic       stop;    // field parse finished
  } field_flags_t;

  typedef struct packed {
    logic [nwsa_pkg::ACC_W-1:0] acc;
    field_flags_t               flags;
  } field_state_t;

  // Expected sentence header "$IIMWV"
  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h24;  // $
      3'd1:    ch = 8'h49;  // I
      3'd2:    ch = 8'h49;  // I
      3'd3:    ch = 8'h4D;  // M
      3'd4:    ch = 8'h57;  // W
      3'd5:    ch = 8'h56;  // V
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // One character step of the decimal field parser
  function automatic field_state_t feed_digit(input field_state_t cur, input logic [7:0] c);
    field_state_t nxt;
    logic [20:0]  v;
    logic [20:0]  d;
    nxt = cur;
    v   = 21'(cur.acc);
    d   = 21'(c[3:0]);
    if (!cur.flags.stop) begin
      if (c == CHAR_POINT) begin
        if (cur.flags.point) begin
          nxt.flags.stop = 1'b1;
        end else begin
          nxt.flags.point = 1'b1;
        end
      end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
        nxt.flags.stop = 1'b1;
      end else begin
        if (!cur.flags.point) begin
          v = 21'(v * 21'd10) + 21'(d * 21'd100);
        end else if (cur.flags.frac == 2'd0) begin
          v = v + 21'(d * 21'd10);
          nxt.flags.frac = 2'd1;
        end else if (cur.flags.frac == 2'd1) begin
          v = v + d;
          nxt.flags.frac = 2'd2;
        end
        if (v > SAT_VALUE) begin
          v = SAT_VALUE;
        end
        nxt.acc = v[nwsa_pkg::ACC_W-1:0];
      end
    end
    return nxt;
  endfunction

  logic [POS_W-1:0] line_position;
  logic             header_match;
  field_state_t     dir_field;
  field_state_t     spd_field;
  logic             line_end;

  // A '$' past the first position closes the sentence
  assign line_end = (rx_byte == CHAR_DOLLAR) && (line_position != '0);
  assign push     = in_fire && line_end && header_match && (line_position >= HEADER_LEN);
  assign push_data.dir_accum   = dir_field.acc;
  assign push_data.speed_accum = spd_field.acc;

  // Line state; the closing '$' opens the next line as its first byte
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
      header_match  <= 1'b1;
      dir_field     <= '0;
      spd_field     <= '0;
    end else if (in_fire) begin
      if (line_end) begin
        line_position <= POS_W'(1);
        header_match  <= 1'b1;
        dir_field     <= '0;
        spd_field     <= '0;
      end else begin
        if (line_position < HEADER_LEN) begin
          if (rx_byte != header_char(line_position[2:0])) begin
            header_match <= 1'b0;
          end
        end else if (line_position >= DIR_FIRST && line_position <= DIR_LAST) begin
          dir_field <= feed_digit(dir_field, rx_byte);
        end else if (line_position >= SPD_FIRST && line_position <= SPD_LAST) begin
          spd_field <= feed_digit(spd_field, rx_byte);
        end
        if (line_position != POS_MAX) begin
          line_position <= line_position + POS_W'(1);
        end
      end
    end
  end

  `CHECK_RST(a_push_restarts_line, push |=> (line_position == POS_W'(1)) && header_match, "line not restarted after sentence")

endmodule

[hw/rtl/nwsa_queue.sv]
// nwsa_queue: short FIFO of sentence requests between front and back end.
// Depends on nwsa_pkg for the entry type and depth.
`include "assert_macros.svh"

module nwsa_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  nwsa_pkg::sentence_t push_data,
  input  logic                pop,
  output logic                valid,
  output logic                full,
  output nwsa_pkg::sentence_t head
);

  localparam int DEPTH = nwsa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  nwsa_pkg::sentence_t entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign valid   = (count != '0);
  assign full    = (count == CNT_FULL);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `CHECK_RST(a_q_no_overflow, push |-> !full || pop, "request pushed into full queue")

endmodule

[hw/rtl/nwsa_back.sv]
// nwsa_back: unit conversion, limit check, averaging rings and output register.
// Depends on nwsa_pkg; pops sentence requests from nwsa_queue.
`include "assert_macros.svh"

module nwsa_back #(
  parameter int SAMPLE_COUNT = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  nwsa_pkg::sentence_t               q_data,
  output logic                              q_pop,
  input  logic [nwsa_pkg::SPD_W-1:0]        speed_limit_milli,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              rejected,
  output logic signed [nwsa_pkg::DIR_W-1:0] direction_centideg,
  output logic [nwsa_pkg::SPD_W-1:0]        speed_milli,
  output logic signed [nwsa_pkg::DIR_W-1:0] avg_direction_centideg,
  output logic [nwsa_pkg::SPD_W-1:0]        avg_speed_milli
);

  localparam int ACC_W  = nwsa_pkg::ACC_W;
  localparam int DIR_W  = nwsa_pkg::DIR_W;
  localparam int SPD_W  = nwsa_pkg::SPD_W;
  localparam int KNOT_W = 19;
  localparam int PROD_W = ACC_W + KNOT_W;
  localparam logic [KNOT_W-1:0] KNOT_TO_MILLI_Q16 = KNOT_W'(337147);

  localparam logic signed [DIR_W:0] HALF_TURN = (DIR_W+1)'(18000);
  localparam logic signed [DIR_W:0] FULL_TURN = (DIR_W+1)'(36000);

  localparam int SLOT_W  = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int CNT_LOG = $clog2(SAMPLE_COUNT);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SAMPLE_COUNT - 1);

  // Ring sums and exact reciprocal multipliers for the division by the ring size
  localparam int SSUM_W  = SPD_W + CNT_LOG;
  localparam int DSUM_W  = DIR_W + CNT_LOG;
  localparam int S_SHIFT = SSUM_W + CNT_LOG;
  localparam int D_SHIFT = DSUM_W + CNT_LOG;
  localparam longint unsigned S_POW = 64'd1 << S_SHIFT;
  localparam longint unsigned D_POW = 64'd1 << D_SHIFT;
  localparam logic [S_SHIFT:0] S_RECIP =
    (S_SHIFT+1)'((S_POW + SAMPLE_COUNT - 1) / SAMPLE_COUNT);
  localparam logic [D_SHIFT:0] D_RECIP =
    (D_SHIFT+1)'((D_POW + SAMPLE_COUNT - 1) / SAMPLE_COUNT);
  localparam int SPROD_W = SSUM_W + S_SHIFT + 1;
  localparam int DPROD_W = DSUM_W + D_SHIFT + 1;
  localparam logic [SSUM_W-1:0] SSUM_MAX = SSUM_W'(SAMPLE_COUNT * 514440);

  logic en;

  // Stage 1: direction wrap and knot-to-milli product
  logic                    s1_valid;
  logic signed [DIR_W-1:0] s1_dir;
  logic [PROD_W-1:0]       s1_prod;
  logic signed [DIR_W:0]   dir_wide;
  logic signed [DIR_W:0]   dir_wrapped;

  // Stage 2: limit check and ring update
  logic                     s2_valid;
  logic                     s2_rej;
  logic                     s2_first;
  logic signed [DIR_W-1:0]  s2_dir;
  logic [SPD_W-1:0]         s2_spd;
  logic signed [DSUM_W-1:0] s2_dsum;
  logic [SSUM_W-1:0]        s2_ssum;

  logic signed [DIR_W-1:0]  dir_ring [SAMPLE_COUNT];
  logic [SPD_W-1:0]         spd_ring [SAMPLE_COUNT];
  logic [SLOT_W-1:0]        ring_slot;
  logic                     first_sample;
  logic signed [DSUM_W-1:0] dir_sum;
  logic [SSUM_W-1:0]        spd_sum;
  logic [SPD_W-1:0]         spd;
  logic                     rej;
  logic signed [DSUM_W-1:0] dir_sum_next;
  logic [SSUM_W-1:0]        spd_sum_next;

  // Stage 3: reciprocal multiplies
  logic                    s3_valid;
  logic                    s3_rej;
  logic                    s3_first;
  logic signed [DIR_W-1:0] s3_dir;
  logic [SPD_W-1:0]        s3_spd;
  logic                    s3_dneg;
  logic [DPROD_W-1:0]      s3_dprod;
  logic [SPROD_W-1:0]      s3_sprod;
  logic [DSUM_W-1:0]       dir_mag;

  // Output stage
  logic signed [DIR_W-1:0] avg_dir_reg;
  logic [SPD_W-1:0]        avg_speed_reg;
  logic [DSUM_W-1:0]       dir_quot;
  logic [SPD_W-1:0]        spd_quot;
  logic signed [DIR_W-1:0] avg_dir_calc;
  logic signed [DIR_W-1:0] avg_dir_next;
  logic [SPD_W-1:0]        avg_speed_next;

  // Whole pipeline advances while the output register can take a result
  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  // Stage 1
  always_comb begin
    dir_wide    = signed'({1'b0, q_data.dir_accum});
    dir_wrapped = (dir_wide > HALF_TURN) ? dir_wide - FULL_TURN : dir_wide;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_dir  <= dir_wrapped[DIR_W-1:0];
      s1_prod <= PROD_W'(q_data.speed_accum) * PROD_W'(KNOT_TO_MILLI_Q16);
    end
  end

  // Stage 2
  always_comb begin
    spd          = s1_prod[16 +: SPD_W];
    rej          = spd > speed_limit_milli;
    dir_sum_next = dir_sum - DSUM_W'(dir_ring[ring_slot]) + DSUM_W'(s1_dir);
    spd_sum_next = spd_sum - SSUM_W'(spd_ring[ring_slot]) + SSUM_W'(spd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
        dir_ring[i] <= '0;
        spd_ring[i] <= '0;
      end
      ring_slot    <= '0;
      first_sample <= 1'b1;
      dir_sum      <= '0;
      spd_sum      <= '0;
      s2_valid     <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      if (s1_valid && !rej) begin
        dir_ring[ring_slot] <= s1_dir;
        spd_ring[ring_slot] <= spd;
        ring_slot           <= (ring_slot == SLOT_LAST) ? '0 : ring_slot + SLOT_W'(1);
        first_sample        <= 1'b0;
        dir_sum             <= dir_sum_next;
        spd_sum             <= spd_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      s2_rej   <= rej;
      s2_first <= first_sample && !rej;
      s2_dir   <= s1_dir;
      s2_spd   <= spd;
      s2_dsum  <= dir_sum_next;
      s2_ssum  <= spd_sum_next;
    end
  end

  // Stage 3: sign-magnitude split for truncation toward zero
  assign dir_mag = s2_dsum[DSUM_W-1] ? unsigned'(-s2_dsum) : unsigned'(s2_dsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      s3_rej   <= s2_rej;
      s3_first <= s2_first;
      s3_dir   <= s2_dir;
      s3_spd   <= s2_spd;
      s3_dneg  <= s2_dsum[DSUM_W-1];
      s3_dprod <= DPROD_W'(dir_mag) * DPROD_W'(D_RECIP);
      s3_sprod <= SPROD_W'(s2_ssum) * SPROD_W'(S_RECIP);
    end
  end

  // Output stage: quotient, sign restore and average selection
  always_comb begin
    dir_quot     = s3_dprod[D_SHIFT +: DSUM_W];
    spd_quot     = s3_sprod[S_SHIFT +: SPD_W];
    avg_dir_calc = s3_dneg ? DIR_W'(-dir_quot) : DIR_W'(dir_quot);
    priority if (s3_rej) begin
      avg_dir_next   = avg_dir_reg;
      avg_speed_next = avg_speed_reg;
    end else if (s3_first) begin
      avg_dir_next   = s3_dir;
      avg_speed_next = s3_spd;
    end else begin
      avg_dir_next   = avg_dir_calc;
      avg_speed_next = spd_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      avg_dir_reg   <= '0;
      avg_speed_reg <= '0;
    end else if (en) begin
      out_valid <= s3_valid;
      if (s3_valid) begin
        avg_dir_reg   <= avg_dir_next;
        avg_speed_reg <= avg_speed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_valid) begin
      rejected               <= s3_rej;
      direction_centideg     <= s3_dir;
      speed_milli            <= s3_spd;
      avg_direction_centideg <= avg_dir_next;
      avg_speed_milli        <= avg_speed_next;
    end
  end

  `CHECK_ALWAYS(a_rst_clears_pipe, rst |=> !out_valid && !s1_valid && !s2_valid && !s3_valid, "pipeline not cleared by reset")
  `CHECK_RST(a_spd_sum_bound, spd_sum <= SSUM_MAX, "speed ring sum out of range")
  `CHECK_RST(a_stall_holds_ring, !en |=> $stable(ring_slot) && $stable(spd_sum), "ring moved during stall")

endmodule
